// ----- hdl/hsktrk_pkg.sv -----
package hsktrk_pkg;

    localparam int SlotCount = 6;
    localparam int UsageWidth = 8;
    localparam int KeyWidth = 4;

    typedef logic [UsageWidth-1:0] t_usage;
    typedef logic [KeyWidth-1:0] t_key;

    typedef enum logic {
        OP_PRESS   = 1'b0,
        OP_RELEASE = 1'b1
    } t_opcode;

    localparam t_key KeyUp     = 4'd0;
    localparam t_key KeyDown   = 4'd1;
    localparam t_key KeyLeft   = 4'd2;
    localparam t_key KeyRight  = 4'd3;
    localparam t_key KeyCentre = 4'd4;
    localparam t_key KeyA      = 4'd5;
    localparam t_key KeyB      = 4'd6;
    localparam t_key KeyX      = 4'd7;
    localparam t_key KeyY      = 4'd8;

    localparam t_usage UsageNone   = 8'h00;
    localparam t_usage UsageUp     = 8'h52;
    localparam t_usage UsageDown   = 8'h51;
    localparam t_usage UsageLeft   = 8'h50;
    localparam t_usage UsageRight  = 8'h4F;
    localparam t_usage UsageSpace  = 8'h2C;
    localparam t_usage UsageDelete = 8'h2A;
    localparam t_usage UsageEnter  = 8'h28;
    localparam t_usage UsageEscape = 8'h29;
    localparam t_usage UsageTab    = 8'h2B;

    // Command broadcast to every slot cell for one accepted event.
    typedef struct packed {
        logic   apply;
        logic   release_op;
        t_usage usage;
    } t_cell_cmd;

    // Ripple flags handed from one slot cell to the next.
    typedef struct packed {
        logic done;
        logic hit;
    } t_chain;

    function automatic t_usage usage_of_key(input t_key key);
        t_usage usage;
        unique case (key)
            KeyUp:     usage = UsageUp;
            KeyDown:   usage = UsageDown;
            KeyLeft:   usage = UsageLeft;
            KeyRight:  usage = UsageRight;
            KeyCentre: usage = UsageSpace;
            KeyA:      usage = UsageDelete;
            KeyB:      usage = UsageEnter;
            KeyX:      usage = UsageEscape;
            KeyY:      usage = UsageTab;
            default:   usage = UsageNone;
        endcase
        return usage;
    endfunction

endpackage

// ----- hdl/hsktrk_evt_if.sv -----
interface hsktrk_evt_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [hsktrk_pkg::KeyWidth-1:0] key_index;

    modport source (output valid, output opcode, output key_index, input ready);
    modport sink (input valid, input opcode, input key_index, output ready);
endinterface

// ----- hdl/hsktrk_rpt_if.sv -----
interface hsktrk_rpt_if;
    logic                 valid;
    logic                 ready;
    hsktrk_pkg::t_usage   slot_zero;
    hsktrk_pkg::t_usage   slot_one;
    hsktrk_pkg::t_usage   slot_two;
    hsktrk_pkg::t_usage   slot_three;
    hsktrk_pkg::t_usage   slot_four;
    hsktrk_pkg::t_usage   slot_five;

    modport source (
        output valid, output slot_zero, output slot_one, output slot_two,
        output slot_three, output slot_four, output slot_five, input ready
    );
    modport sink (
        input valid, input slot_zero, input slot_one, input slot_two,
        input slot_three, input slot_four, input slot_five, output ready
    );
endinterface

// ----- hdl/hid_six_key_report_tracker_top.sv -----
// The report for an event is valid in the cycle after its transfer.
// Throughput: one event per cycle while the output is not stalled; the six slot cells update together.
// A new event is taken while the output is empty or being taken in the same cycle.
// Reset (synchronous, active low) clears all six slots and the output valid flag.
module hid_six_key_report_tracker_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    hsktrk_evt_if.sink   i_evt,
    hsktrk_rpt_if.source o_rpt
);

    localparam int SlotCount = hsktrk_pkg::SlotCount;

    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  w_accept;
    hsktrk_pkg::t_usage    w_usage;
    hsktrk_pkg::t_cell_cmd w_cmd;
    hsktrk_pkg::t_chain    w_chain [SlotCount+1];
    hsktrk_pkg::t_usage    w_slot  [SlotCount];

    assign i_evt.ready = !r_out_valid || o_rpt.ready;
    assign w_accept    = i_evt.valid && i_evt.ready;
    assign w_usage     = hsktrk_pkg::usage_of_key(i_evt.key_index);

    assign w_cmd.apply      = w_accept && (w_usage != hsktrk_pkg::UsageNone);
    assign w_cmd.release_op = (i_evt.opcode == hsktrk_pkg::OP_RELEASE);
    assign w_cmd.usage      = w_usage;

    assign w_chain[0] = '0;

    for (genvar g = 0; g < SlotCount; g++) begin : g_cell
        hsktrk_pkg::t_usage w_next;
        if (g == SlotCount - 1) begin : g_last
            assign w_next = hsktrk_pkg::UsageNone;
        end else begin : g_mid
            assign w_next = w_slot[g+1];
        end
        hsktrk_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_chain     (w_chain[g]),
            .i_next_usage(w_next),
            .o_chain     (w_chain[g+1]),
            .o_usage     (w_slot[g])
        );
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (o_rpt.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rpt.valid      = r_out_valid;
    assign o_rpt.slot_zero  = w_slot[0];
    assign o_rpt.slot_one   = w_slot[1];
    assign o_rpt.slot_two   = w_slot[2];
    assign o_rpt.slot_three = w_slot[3];
    assign o_rpt.slot_four  = w_slot[4];
    assign o_rpt.slot_five  = w_slot[5];

endmodule

// ----- hdl/hsktrk_cell.sv -----
module hsktrk_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hsktrk_pkg::t_cell_cmd i_cmd,
    input  hsktrk_pkg::t_chain    i_chain,
    input  hsktrk_pkg::t_usage    i_next_usage,
    output hsktrk_pkg::t_chain    o_chain,
    output hsktrk_pkg::t_usage    o_usage
);

    hsktrk_pkg::t_usage r_usage;
    hsktrk_pkg::t_usage n_usage;
    logic               w_match;
    logic               w_empty;

    assign w_match = (r_usage == i_cmd.usage);
    assign w_empty = (r_usage == hsktrk_pkg::UsageNone);

    assign o_chain.done = i_chain.done | w_match | w_empty;
    assign o_chain.hit  = i_chain.hit | w_match;
    assign o_usage      = r_usage;

    // A release shifts the slots behind the removed usage one place forward.
    // A press fills the first empty slot when no earlier slot holds the usage.
    always_comb begin
        n_usage = r_usage;
        if (i_cmd.apply) begin
            if (i_cmd.release_op) begin
                if (o_chain.hit) begin
                    n_usage = i_next_usage;
                end
            end else if (!i_chain.done && w_empty) begin
                n_usage = i_cmd.usage;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usage <= hsktrk_pkg::UsageNone;
        end else begin
            r_usage <= n_usage;
        end
    end

endmodule
